>>> rtl/affine_2d_matrix_and_inverse_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef AFFINE_2D_MATRIX_AND_INVERSE_ASSERT_SVH
`define AFFINE_2D_MATRIX_AND_INVERSE_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define AFM_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("afm: same-cycle check failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define AFM_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("afm: next-cycle check failed");

`endif

>>> rtl/afm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package afm_pkg;

  localparam int ANGLE_BITS       = 16;
  localparam int SINCOS_FRAC_BITS = 16;

  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int XW           = 32;
  localparam int ZW           = 32;

  // Rounded sine and cosine, with room for a gain slightly above one.
  localparam int CW  = SINCOS_FRAC_BITS + 2;
  // Dividend and quotient width of the divider lanes, and divisor width.
  localparam int DW  = SINCOS_FRAC_BITS + 33;
  localparam int DVW = SINCOS_FRAC_BITS + 8;

  localparam int IN_W  = 112;
  localparam int OUT_W = 200;

  localparam logic signed [XW-1:0] CORDIC_X0 = 32'sd652032874;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [1:0]         quad;
  } pay_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    pay_t                 pay;
  } cor_t;

  typedef struct packed {
    logic [DW-1:0]  nq;
    logic [DVW-1:0] r;
    logic [DVW-1:0] d;
  } div_t;

  // Arctangent of 2^-i in units of 2^32 per full turn.
  function automatic logic signed [ZW-1:0] atan_step(input logic [STEP_W-1:0] idx);
    logic signed [ZW-1:0] a;
    case (idx)
      5'd0:  a = 32'sh20000000;
      5'd1:  a = 32'sh12E4051E;
      5'd2:  a = 32'sh09FB385B;
      5'd3:  a = 32'sh051111D4;
      5'd4:  a = 32'sh028B0D43;
      5'd5:  a = 32'sh0145D7E1;
      5'd6:  a = 32'sh00A2F61E;
      5'd7:  a = 32'sh00517C55;
      5'd8:  a = 32'sh0028BE53;
      5'd9:  a = 32'sh00145F2F;
      5'd10: a = 32'sh000A2F98;
      5'd11: a = 32'sh000517CC;
      5'd12: a = 32'sh00028BE6;
      5'd13: a = 32'sh000145F3;
      5'd14: a = 32'sh0000A2FA;
      5'd15: a = 32'sh0000517D;
      5'd16: a = 32'sh000028BE;
      5'd17: a = 32'sh0000145F;
      5'd18: a = 32'sh00000A30;
      5'd19: a = 32'sh00000518;
      5'd20: a = 32'sh0000028C;
      5'd21: a = 32'sh00000146;
      5'd22: a = 32'sh000000A3;
      5'd23: a = 32'sh00000051;
      5'd24: a = 32'sh00000029;
      5'd25: a = 32'sh00000014;
      5'd26: a = 32'sh0000000A;
      5'd27: a = 32'sh00000005;
      5'd28: a = 32'sh00000003;
      5'd29: a = 32'sh00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

>>> rtl/affine_2d_matrix_and_inverse.sv
// 2D affine matrix and inverse from position, angle and per-axis scale.
// Input channel in_*: one item per handshake carries pos_x, pos_y, angle,
// scale_x and scale_y. Output channel out_*: each input item gives two items,
// first the forward matrix, then the inverse matrix with out_tlast high.
// The forward item is shown on out_tvalid once the input has passed every
// stage below and the output register; the inverse follows once it is taken.
// Two output items per input item; when the last stage holds an item, the
// single output register that shows both items sets the input rate.
// Data path: 30 CORDIC cells, a rounding stage, a multiply stage, a sum stage,
// an operand stage and six restoring divider lanes of 33 + SINCOS_FRAC_BITS
// cells each, all advancing together one stage per cycle while adv is high.
// Reset clears all valid bits; the pipeline then holds no items.
// When the receiver stalls with both results pending, the pipeline freezes
// only once its last stage holds an item; until then in_tready stays high.
`timescale 1ns / 1ps
`default_nettype none

module affine_2d_matrix_and_inverse (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // pos_x[31:0], pos_y[63:32], angle[79:64], scale_x[95:80], scale_y[111:96]
  input  logic [afm_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // elem_a[31:0], elem_b[63:32], elem_c[95:64], elem_d[127:96],
  // trans_x[159:128], trans_y[191:160], saturated[192], div_zero[193], zeros
  output logic [afm_pkg::OUT_W-1:0]  out_tdata,
  // is_inverse
  output logic                       out_tlast
);
  import afm_pkg::*;

  localparam int F    = SINCOS_FRAC_BITS;
  localparam int NL   = 6;
  localparam int PSH  = 32 - ANGLE_BITS;
  localparam int TS   = 30 - F;
  localparam int MS   = F - 8;
  localparam int MHALF = (MS > 0) ? (1 << (MS - 1)) : 0;
  localparam int LS   = 24 - F;
  localparam int TDS  = F - 8;
  localparam int PW   = 32 + CW;
  localparam int FPW  = CW + 16;
  localparam int NW   = PW + 1;

  localparam logic [31:0]          AMASK  = 32'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam logic signed [XW-1:0] THALF  = XW'(64'd1 << (TS - 1));
  localparam logic signed [63:0]   MAX64  = 64'sh000000007FFFFFFF;
  localparam logic signed [63:0]   MIN64  = -64'sh0000000080000000;
  localparam logic [31:0]          MAX32  = 32'h7FFFFFFF;
  localparam logic [31:0]          MIN32  = 32'h80000000;
  localparam logic [DW:0]          M_NEG  = (DW + 1)'(64'h80000000);
  localparam logic [DW:0]          M_POS  = (DW + 1)'(64'h7FFFFFFF);

  typedef struct packed {
    logic signed [31:0]   px;
    logic signed [31:0]   py;
    logic signed [15:0]   sx;
    logic signed [15:0]   sy;
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] s;
  } trig_t;

  typedef struct packed {
    trig_t                 t;
    logic signed [PW-1:0]  pcx;
    logic signed [PW-1:0]  psy;
    logic signed [PW-1:0]  psx;
    logic signed [PW-1:0]  pcy;
    logic signed [FPW-1:0] ma;
    logic signed [FPW-1:0] mb;
    logic signed [FPW-1:0] mc;
    logic signed [FPW-1:0] md;
  } prod_t;

  typedef struct packed {
    trig_t                t;
    logic [31:0]          fa;
    logic [31:0]          fb;
    logic [31:0]          fc;
    logic [31:0]          fd;
    logic                 fsat;
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
  } sum_t;

  typedef struct packed {
    logic [31:0]   px;
    logic [31:0]   py;
    logic [31:0]   fa;
    logic [31:0]   fb;
    logic [31:0]   fc;
    logic [31:0]   fd;
    logic          fsat;
    logic [NL-1:0] neg;
    logic [NL-1:0] zero;
    logic [NL-1:0] numneg;
  } side_t;

  // Item layout on tdata, elem_a in the lowest bits.
  typedef struct packed {
    logic        dz;
    logic        sat;
    logic [31:0] ty;
    logic [31:0] tx;
    logic [31:0] d;
    logic [31:0] c;
    logic [31:0] b;
    logic [31:0] a;
  } res_t;

  function automatic logic [32:0] rnd_sat(input logic signed [FPW-1:0] p);
    logic signed [FPW-1:0] t;
    logic [32:0]           res;
    t = (p + FPW'(MHALF)) >>> MS;
    if (64'(t) > MAX64) begin
      res = {1'b1, MAX32};
    end else if (64'(t) < MIN64) begin
      res = {1'b1, MIN32};
    end else begin
      res = {1'b0, 32'(t)};
    end
    return res;
  endfunction

  function automatic logic [CW-1:0] mag_cw(input logic signed [CW-1:0] v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  function automatic logic [NW-1:0] mag_nw(input logic signed [NW-1:0] v);
    return v[NW-1] ? NW'(-v) : NW'(v);
  endfunction

  function automatic logic [15:0] mag_16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  // Returns {div_zero, saturated, value} for one inverse term.
  function automatic logic [33:0] fin_lane(input logic [DW-1:0] q,
                                           input logic [DVW-1:0] r,
                                           input logic [DVW-1:0] d,
                                           input logic neg,
                                           input logic zero,
                                           input logic numneg);
    logic        rnd;
    logic [DW:0] m;
    logic [33:0] res;
    rnd = ({r, 1'b0} >= {1'b0, d});
    m   = {1'b0, q} + (DW + 1)'(rnd);
    if (zero) begin
      res = {2'b11, numneg ? MIN32 : MAX32};
    end else if (neg) begin
      res = (m > M_NEG) ? {2'b01, MIN32} : {2'b00, -(m[31:0])};
    end else begin
      res = (m > M_POS) ? {2'b01, MAX32} : {2'b00, m[31:0]};
    end
    return res;
  endfunction

  logic                 adv;
  logic                 free;
  logic [31:0]          phase;

  logic [CORDIC_STEPS:0] cor_v;
  cor_t                  cor_d [CORDIC_STEPS+1];

  trig_t                a_r;
  trig_t                a_nxt;
  logic                 a_v_r;
  logic signed [XW-1:0] xr;
  logic signed [XW-1:0] yr;
  logic signed [CW-1:0] xc;
  logic signed [CW-1:0] yc;

  prod_t                b_r;
  prod_t                b_nxt;
  logic                 b_v_r;
  logic signed [CW-1:0] ns;

  sum_t                 c_r;
  sum_t                 c_nxt;
  logic                 c_v_r;
  logic [32:0]          rs_a;
  logic [32:0]          rs_b;
  logic [32:0]          rs_c;
  logic [32:0]          rs_d;

  div_t                 dp_r   [NL];
  div_t                 dp_nxt [NL];
  side_t                side_nxt;
  side_t                side_r [DW+1];
  logic [DW:0]          sv_r;
  logic [15:0]          msx;
  logic [15:0]          msy;
  logic [NL-1:0]        denneg;

  div_t                 divc [NL][DW+1];

  logic [33:0]          fin [NL];
  res_t                 fwd_res;
  res_t                 inv_res;
  res_t                 ob_fwd_r;
  res_t                 ob_inv_r;
  logic                 ob_valid_r;
  logic                 ob_phase_r;

  // The whole pipeline moves together; it may always move while its last
  // stage is empty.
  assign free      = !ob_valid_r || (out_tready && ob_phase_r);
  assign adv       = !sv_r[DW] || free;
  assign in_tready = adv;

  assign phase = (32'(in_tdata[79:64]) & AMASK) << PSH;

  assign cor_v[0]          = in_tvalid;
  assign cor_d[0].x        = CORDIC_X0;
  assign cor_d[0].y        = '0;
  assign cor_d[0].z        = ZW'({2'b00, phase[29:0]});
  assign cor_d[0].pay.px   = in_tdata[31:0];
  assign cor_d[0].pay.py   = in_tdata[63:32];
  assign cor_d[0].pay.sx   = in_tdata[95:80];
  assign cor_d[0].pay.sy   = in_tdata[111:96];
  assign cor_d[0].pay.quad = phase[31:30];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    afm_cordic_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .idx   (STEP_W'(k)),
      .v_in  (cor_v[k]),
      .prev  (cor_d[k]),
      .v_out (cor_v[k+1]),
      .cur   (cor_d[k+1])
    );
  end

  // Round the CORDIC outputs and fold the quadrant back in.
  always_comb begin
    xr       = (cor_d[CORDIC_STEPS].x + THALF) >>> TS;
    yr       = (cor_d[CORDIC_STEPS].y + THALF) >>> TS;
    xc       = CW'(xr);
    yc       = CW'(yr);
    a_nxt.px = cor_d[CORDIC_STEPS].pay.px;
    a_nxt.py = cor_d[CORDIC_STEPS].pay.py;
    a_nxt.sx = cor_d[CORDIC_STEPS].pay.sx;
    a_nxt.sy = cor_d[CORDIC_STEPS].pay.sy;
    case (cor_d[CORDIC_STEPS].pay.quad)
      2'd0: begin
        a_nxt.c = xc;
        a_nxt.s = yc;
      end
      2'd1: begin
        a_nxt.c = -yc;
        a_nxt.s = xc;
      end
      2'd2: begin
        a_nxt.c = -xc;
        a_nxt.s = -yc;
      end
      default: begin
        a_nxt.c = yc;
        a_nxt.s = -xc;
      end
    endcase
  end

  always_comb begin
    ns        = -a_r.s;
    b_nxt.t   = a_r;
    b_nxt.pcx = a_r.px * a_r.c;
    b_nxt.psy = a_r.py * a_r.s;
    b_nxt.psx = a_r.px * a_r.s;
    b_nxt.pcy = a_r.py * a_r.c;
    b_nxt.ma  = a_r.c * a_r.sx;
    b_nxt.mb  = ns * a_r.sy;
    b_nxt.mc  = a_r.s * a_r.sx;
    b_nxt.md  = a_r.c * a_r.sy;
  end

  always_comb begin
    rs_a       = rnd_sat(b_r.ma);
    rs_b       = rnd_sat(b_r.mb);
    rs_c       = rnd_sat(b_r.mc);
    rs_d       = rnd_sat(b_r.md);
    c_nxt.t    = b_r.t;
    c_nxt.fa   = rs_a[31:0];
    c_nxt.fb   = rs_b[31:0];
    c_nxt.fc   = rs_c[31:0];
    c_nxt.fd   = rs_d[31:0];
    c_nxt.fsat = rs_a[32] | rs_b[32] | rs_c[32] | rs_d[32];
    c_nxt.nx   = -NW'(b_r.pcx) - NW'(b_r.psy);
    c_nxt.ny   = NW'(b_r.psx) - NW'(b_r.pcy);
  end

  // Divider operands: magnitudes, signs and zero-scale flags for six terms.
  // Lanes: cos/sx, sin/sx, -sin/sy, cos/sy, nx/sx, ny/sy.
  always_comb begin
    msx = mag_16(c_r.t.sx);
    msy = mag_16(c_r.t.sy);

    dp_nxt[0].nq = DW'(mag_cw(c_r.t.c)) << LS;
    dp_nxt[1].nq = DW'(mag_cw(c_r.t.s)) << LS;
    dp_nxt[2].nq = DW'(mag_cw(c_r.t.s)) << LS;
    dp_nxt[3].nq = DW'(mag_cw(c_r.t.c)) << LS;
    dp_nxt[4].nq = DW'(mag_nw(c_r.nx));
    dp_nxt[5].nq = DW'(mag_nw(c_r.ny));

    dp_nxt[0].d = DVW'(msx);
    dp_nxt[1].d = DVW'(msx);
    dp_nxt[2].d = DVW'(msy);
    dp_nxt[3].d = DVW'(msy);
    dp_nxt[4].d = DVW'(msx) << TDS;
    dp_nxt[5].d = DVW'(msy) << TDS;

    for (int l = 0; l < NL; l++) begin
      dp_nxt[l].r = '0;
    end

    side_nxt.numneg[0] = c_r.t.c[CW-1];
    side_nxt.numneg[1] = c_r.t.s[CW-1];
    side_nxt.numneg[2] = !c_r.t.s[CW-1] && (c_r.t.s != '0);
    side_nxt.numneg[3] = c_r.t.c[CW-1];
    side_nxt.numneg[4] = c_r.nx[NW-1];
    side_nxt.numneg[5] = c_r.ny[NW-1];

    denneg = {c_r.t.sy[15], c_r.t.sx[15], c_r.t.sy[15],
              c_r.t.sy[15], c_r.t.sx[15], c_r.t.sx[15]};
    side_nxt.zero = {c_r.t.sy == '0, c_r.t.sx == '0, c_r.t.sy == '0,
                     c_r.t.sy == '0, c_r.t.sx == '0, c_r.t.sx == '0};
    side_nxt.neg  = side_nxt.numneg ^ denneg;

    side_nxt.px   = c_r.t.px;
    side_nxt.py   = c_r.t.py;
    side_nxt.fa   = c_r.fa;
    side_nxt.fb   = c_r.fb;
    side_nxt.fc   = c_r.fc;
    side_nxt.fd   = c_r.fd;
    side_nxt.fsat = c_r.fsat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      sv_r  <= '0;
    end else if (adv) begin
      a_v_r <= cor_v[CORDIC_STEPS];
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      sv_r  <= {sv_r[DW-1:0], c_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r       <= a_nxt;
      b_r       <= b_nxt;
      c_r       <= c_nxt;
      dp_r      <= dp_nxt;
      side_r[0] <= side_nxt;
      for (int j = 0; j < DW; j++) begin
        side_r[j+1] <= side_r[j];
      end
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_lane
    assign divc[l][0] = dp_r[l];
    for (genvar j = 0; j < DW; j++) begin : g_cell
      afm_div_cell u_cell (
        .clk  (clk),
        .en   (adv),
        .prev (divc[l][j]),
        .cur  (divc[l][j+1])
      );
    end
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      fin[l] = fin_lane(divc[l][DW].nq, divc[l][DW].r, divc[l][DW].d,
                        side_r[DW].neg[l], side_r[DW].zero[l],
                        side_r[DW].numneg[l]);
    end

    fwd_res.a   = side_r[DW].fa;
    fwd_res.b   = side_r[DW].fb;
    fwd_res.c   = side_r[DW].fc;
    fwd_res.d   = side_r[DW].fd;
    fwd_res.tx  = side_r[DW].px;
    fwd_res.ty  = side_r[DW].py;
    fwd_res.sat = side_r[DW].fsat;
    fwd_res.dz  = 1'b0;

    inv_res.a   = fin[0][31:0];
    inv_res.b   = fin[1][31:0];
    inv_res.c   = fin[2][31:0];
    inv_res.d   = fin[3][31:0];
    inv_res.tx  = fin[4][31:0];
    inv_res.ty  = fin[5][31:0];
    inv_res.sat = fin[0][32] | fin[1][32] | fin[2][32] |
                  fin[3][32] | fin[4][32] | fin[5][32];
    inv_res.dz  = fin[0][33] | fin[1][33] | fin[2][33] |
                  fin[3][33] | fin[4][33] | fin[5][33];
  end

  // Output register holds both items of one input; phase picks which shows.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_valid_r <= 1'b0;
      ob_phase_r <= 1'b0;
    end else if (adv && sv_r[DW]) begin
      ob_valid_r <= 1'b1;
      ob_phase_r <= 1'b0;
    end else if (ob_valid_r && out_tready) begin
      if (ob_phase_r) begin
        ob_valid_r <= 1'b0;
        ob_phase_r <= 1'b0;
      end else begin
        ob_phase_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && sv_r[DW]) begin
      ob_fwd_r <= fwd_res;
      ob_inv_r <= inv_res;
    end
  end

  assign out_tvalid = ob_valid_r;
  assign out_tlast  = ob_phase_r;
  assign out_tdata  = OUT_W'(ob_phase_r ? ob_inv_r : ob_fwd_r);

endmodule

`default_nettype wire

>>> rtl/afm_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module afm_cordic_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [afm_pkg::STEP_W-1:0]  idx,
  input  logic                        v_in,
  input  afm_pkg::cor_t               prev,
  output logic                        v_out,
  output afm_pkg::cor_t               cur
);
  import afm_pkg::*;

  logic                 v_r;
  cor_t                 cur_r;
  cor_t                 cur_nxt;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] at;

  always_comb begin
    dx      = prev.y >>> idx;
    dy      = prev.x >>> idx;
    at      = atan_step(idx);
    cur_nxt = prev;
    if (!prev.z[ZW-1]) begin
      cur_nxt.x = prev.x - dx;
      cur_nxt.y = prev.y + dy;
      cur_nxt.z = prev.z - at;
    end else begin
      cur_nxt.x = prev.x + dx;
      cur_nxt.y = prev.y - dy;
      cur_nxt.z = prev.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cur_r <= cur_nxt;
    end
  end

  assign v_out = v_r;
  assign cur   = cur_r;

endmodule

`default_nettype wire

>>> rtl/afm_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module afm_div_cell (
  input  logic          clk,
  input  logic          en,
  input  afm_pkg::div_t prev,
  output afm_pkg::div_t cur
);
  import afm_pkg::*;

  div_t           cur_r;
  div_t           cur_nxt;
  logic [DVW:0]   trial;
  logic           ge;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  always_comb begin
    trial          = {prev.r, prev.nq[DW-1]};
    ge             = (trial >= {1'b0, prev.d});
    cur_nxt.d      = prev.d;
    cur_nxt.nq     = {prev.nq[DW-2:0], ge};
    cur_nxt.r      = ge ? DVW'(trial - {1'b0, prev.d}) : trial[DVW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cur_r <= cur_nxt;
    end
  end

  assign cur = cur_r;

endmodule

`default_nettype wire

>>> rtl/afm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "affine_2d_matrix_and_inverse_assert.svh"

module afm_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [afm_pkg::OUT_W-1:0] out_tdata,
  input logic                      out_tlast
);
  import afm_pkg::*;

  localparam int SAT_BIT = 192;
  localparam int DZ_BIT  = 193;

  // The forward item is never flagged for a zero scale.
  `AFM_ASSERT_NOW(a_fwd_no_dz, out_tvalid && !out_tlast, !out_tdata[DZ_BIT])

  // A zero scale always sets the saturated flag of the inverse item.
  `AFM_ASSERT_NOW(a_dz_sat, out_tvalid && out_tlast && out_tdata[DZ_BIT], out_tdata[SAT_BIT])

  // The inverse item is ready as soon as its forward item is taken.
  `AFM_ASSERT_NEXT(a_inv_follows, out_tvalid && out_tready && !out_tlast, out_tvalid && out_tlast)

  // After an inverse item the next item shown is a forward one.
  `AFM_ASSERT_NEXT(a_fwd_after_inv, out_tvalid && out_tready && out_tlast, !out_tlast)

  // A stalled item holds its contents.
  `AFM_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

endmodule

bind affine_2d_matrix_and_inverse afm_checker u_afm_checker (.*);

`default_nettype wire

>>> sim/affine_2d_matrix_and_inverse_tb.sv
`timescale 1ns / 1ps

module affine_2d_matrix_and_inverse_tb;

  localparam int ITEMS_PER_PHASE = 462;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 150;

  // Arctangent of 2^-i, 2^32 units per full turn.
  localparam longint ATAN_TURN [30] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

  // Matrix item fields: 0 is_inverse, 1..6 terms a b c d tx ty, 7 saturated, 8 div_zero.
  typedef bit [8:0][31:0] matrix_item_t;

  class matrix_scoreboard;
    matrix_item_t expected_q[$];
    int errors;
    string field_name [9] = '{"is_inverse", "elem_a", "elem_b", "elem_c", "elem_d",
                              "trans_x", "trans_y", "saturated", "div_zero"};

    function longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function longint clip32(longint v, inout bit sat);
      if (v > 64'sd2147483647) begin
        sat = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        sat = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function void sin_cos(bit [15:0] ang, output longint c, output longint s);
      bit [31:0] phase;
      longint x, y, z, dx, dy;
      phase = {ang, 16'h0};
      z = longint'(phase[29:0]);
      x = 652032874;
      y = 0;
      for (int i = 0; i < 30; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= ATAN_TURN[i];
        end else begin
          x += dx; y -= dy; z += ATAN_TURN[i];
        end
      end
      x = round_shift(x, 14);
      y = round_shift(y, 14);
      case (phase[31:30])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function longint scaled_trig(longint t, longint sc, inout bit sat);
      return clip32(round_shift(t * sc, 8), sat);
    endfunction

    // Rounded quotient num * 2^k / (den * 2^dshift), ties away from zero.
    function longint quotient(longint num, longint den, int dshift, int k,
                              inout bit sat, inout bit dz);
      bit [63:0] n, d, q, r, r2, big;
      bit neg, b;
      if (den == 0) begin
        dz = 1;
        sat = 1;
        return (num < 0) ? -64'sd2147483648 : 64'sd2147483647;
      end
      big = 64'd1 << 33;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = ((den < 0) ? -den : den) << dshift;
      q = n / d;
      r = n % d;
      if (q > big) q = big;
      for (int i = 0; i < k; i++) begin
        r2 = r << 1;
        b = (r2 >= d);
        r = b ? r2 - d : r2;
        if (q < big) q = (q << 1) | b;
      end
      if ((r << 1) >= d && q < big) q++;
      return clip32(neg ? -longint'(q) : longint'(q), sat);
    endfunction

    function void note_input(bit [111:0] data);
      longint px, py, sx, sy, c, s, nx, ny;
      bit sat, dz;
      matrix_item_t fwd, inv;
      px = longint'($signed(data[31:0]));
      py = longint'($signed(data[63:32]));
      sx = longint'($signed(data[95:80]));
      sy = longint'($signed(data[111:96]));
      sin_cos(data[79:64], c, s);
      sat = 0;
      dz = 0;
      fwd[0] = 0;
      fwd[1] = scaled_trig(c, sx, sat);
      fwd[2] = scaled_trig(-s, sy, sat);
      fwd[3] = scaled_trig(s, sx, sat);
      fwd[4] = scaled_trig(c, sy, sat);
      fwd[5] = px;
      fwd[6] = py;
      fwd[7] = sat;
      fwd[8] = 0;
      expected_q.push_back(fwd);
      sat = 0;
      inv[0] = 1;
      inv[1] = quotient(c, sx, 0, 8, sat, dz);
      inv[2] = quotient(s, sx, 0, 8, sat, dz);
      inv[3] = quotient(-s, sy, 0, 8, sat, dz);
      inv[4] = quotient(c, sy, 0, 8, sat, dz);
      nx = -px * c - py * s;
      ny = px * s - py * c;
      inv[5] = quotient(nx, sx, 16, 8, sat, dz);
      inv[6] = quotient(ny, sy, 16, 8, sat, dz);
      inv[7] = sat;
      inv[8] = dz;
      expected_q.push_back(inv);
    endfunction

    function void check_result(bit [199:0] data, bit last);
      matrix_item_t got, want;
      got[0] = last;
      for (int i = 0; i < 6; i++) got[i+1] = data[32*i +: 32];
      got[7] = data[192];
      got[8] = data[193];
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected matrix item, tdata=%h last=%0b", data, last);
        return;
      end
      want = expected_q.pop_front();
      for (int i = 0; i < 9; i++) begin
        if (got[i] != want[i]) begin
          errors++;
          if (errors <= 10)
            $display("%s mismatch: expected %h, got %h", field_name[i], want[i], got[i]);
        end
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [199:0] out_tdata;
  logic         out_tlast;

  matrix_scoreboard sb;
  int idle_pct;
  int stall_pct;
  int cycles;

  affine_2d_matrix_and_inverse dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** affine_2d_matrix_and_inverse: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(bit [111:0] data);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
    sb.note_input(data);
  endtask

  function automatic bit [111:0] pack_item(bit [31:0] px, bit [31:0] py, bit [15:0] ang,
                                           bit [15:0] sx, bit [15:0] sy);
    return {sy, sx, ang, py, px};
  endfunction

  function automatic bit [15:0] pick_scale();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return $urandom_range(1, 4) * ($urandom_range(1) ? -1 : 1);
      2: return $urandom();
      3: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      default: return $urandom_range(1, 1023) * ($urandom_range(1) ? -1 : 1);
    endcase
  endfunction

  function automatic bit [31:0] pick_pos();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      1: return $urandom_range(0, 32'h000F_FFFF) * ($urandom_range(1) ? -1 : 1);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    sb = new();
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Quadrant edges, extreme scales and positions, and zero scales.
    send_item(pack_item(32'h0001_0000, 32'h0002_0000, 16'h0000, 16'h0100, 16'h0100));
    send_item(pack_item(32'h0001_0000, 32'hFFFF_0000, 16'h4000, 16'h0100, 16'h0200));
    send_item(pack_item(32'h0000_0000, 32'h0000_0000, 16'h8000, 16'h0100, 16'h0100));
    send_item(pack_item(32'h0003_8000, 32'h0000_4000, 16'hC000, 16'hFF00, 16'h0080));
    send_item(pack_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF));
    send_item(pack_item(32'h8000_0000, 32'h8000_0000, 16'h2000, 16'h8000, 16'h8000));
    send_item(pack_item(32'h7FFF_FFFF, 32'h8000_0000, 16'h2000, 16'h0001, 16'hFFFF));
    send_item(pack_item(32'h0001_0000, 32'h0001_0000, 16'h1234, 16'h0000, 16'h0100));
    send_item(pack_item(32'h0001_0000, 32'h0001_0000, 16'h6000, 16'h0100, 16'h0000));
    send_item(pack_item(32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(pack_item(32'hFFFF_FFFF, 32'h0000_0001, 16'hA000, 16'h0000, 16'h0000));
    send_item(pack_item(32'h8000_0000, 32'h7FFF_FFFF, 16'hE000, 16'h0001, 16'h0001));
    send_item(pack_item(32'h0010_0000, 32'hFFF0_0000, 16'h0001, 16'h8000, 16'h7FFF));
    send_item(pack_item(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 16'h5555, 16'hAAAA));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 64; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 64; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_item(pack_item(pick_pos(), pick_pos(), $urandom(), pick_scale(), pick_scale()));
    end
    in_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** affine_2d_matrix_and_inverse: PASSED **");
    end else begin
      $display("** affine_2d_matrix_and_inverse: FAILED **");
    end
    $finish;
  end

endmodule
